>>> sv/hmp_pkg.sv
// Shared types, constants and helpers for the rolling median / MAD / Hampel block.
package hmp_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int SAMPLE_BITS = 32;
    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ENTRY_W = SAMPLE_BITS + 1;
    localparam int SVAL_W = SAMPLE_BITS + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [16:0] KAPPA_Q16 = 17'd97164;
    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

    typedef logic signed [SVAL_W-1:0] t_sval;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_MISSING = 2'd1,
        ST_INF     = 2'd2,
        ST_SHORT   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH = 3'd0,
        REG_STEP  = 3'd1,
        REG_ALIGN = 3'd2,
        REG_DROP  = 3'd3,
        REG_STAT  = 3'd4
    } t_reg_idx;

    localparam logic [1:0] AL_LEFT   = 2'd0;
    localparam logic [1:0] AL_CENTER = 2'd1;
    localparam logic [1:0] AL_RIGHT  = 2'd2;

    localparam logic [1:0] SEL_MEDIAN = 2'd0;
    localparam logic [1:0] SEL_MAD    = 2'd1;

    typedef struct packed {
        logic             clear;
        logic             ins;
        t_sval            val;
        logic [IDX_W-1:0] rd_idx;
    } t_sort_ctl;

    function automatic logic [CNT_W-1:0] f_eff_width(input logic [5:0] w);
        logic [CNT_W-1:0] r;
        if (w == 6'd0) begin
            r = CNT_W'(1);
        end else if (w > 6'(MAX_WIDTH)) begin
            r = CNT_W'(MAX_WIDTH);
        end else begin
            r = CNT_W'(w);
        end
        return r;
    endfunction

    function automatic logic [1:0] f_eff_align(input logic [1:0] a);
        return (a > AL_RIGHT) ? AL_RIGHT : a;
    endfunction

    function automatic logic [CNT_W-1:0] f_lo(input logic [CNT_W-1:0] w, input logic [1:0] a);
        logic [CNT_W-1:0] r;
        case (a)
            AL_LEFT:   r = '0;
            AL_CENTER: r = w >> 1;
            default:   r = w - CNT_W'(1);
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_hi(input logic [CNT_W-1:0] w, input logic [1:0] a);
        logic [CNT_W-1:0] r;
        case (a)
            AL_LEFT:   r = w - CNT_W'(1);
            AL_CENTER: r = w >> 1;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] f_delay(input logic [CNT_W-1:0] w,
                                                 input logic [1:0] a);
        logic [CNT_W-1:0] r;
        case (a)
            AL_LEFT:   r = w - CNT_W'(1);
            AL_CENTER: r = w - CNT_W'(1) - (w >> 1);
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/hmp_if.sv
// Stream and configuration channel interfaces for the Hampel block.
interface hmp_in_if;
    import hmp_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_missing;
    logic                          series_end;
    modport source (output valid, sample, sample_missing, series_end, input ready);
    modport sink (input valid, sample, sample_missing, series_end, output ready);
endinterface

interface hmp_out_if;
    import hmp_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] value;
    logic [1:0]                    status;
    logic                          series_last;
    modport source (output valid, value, status, series_last, input ready);
    modport sink (input valid, value, status, series_last, output ready);
endinterface

interface hmp_cfg_if;
    import hmp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/hmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hmp_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/hmp_sorter.sv
// Insertion sorter: a row of cells kept in ascending order, one insert per cycle.
module hmp_sorter import hmp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_sort_ctl        i_ctl,
    output t_sval            o_rd_data,
    output logic [CNT_W-1:0] o_count
);
    t_sval                r_cell [MAX_WIDTH];
    logic [CNT_W-1:0]     r_count;
    logic [MAX_WIDTH-1:0] w_gt;

    always_comb begin
        for (int j = 0; j < MAX_WIDTH; j++) begin
            w_gt[j] = (CNT_W'(j) >= r_count) || (r_cell[j] > i_ctl.val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.clear) begin
            r_count <= '0;
        end else if (i_ctl.ins) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_gt[0]) begin
            r_cell[0] <= i_ctl.val;
        end
    end

    for (genvar j = 1; j < MAX_WIDTH; j++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (i_ctl.ins && w_gt[j]) begin
                r_cell[j] <= w_gt[j-1] ? r_cell[j-1] : i_ctl.val;
            end
        end
    end

    assign o_rd_data = r_cell[i_ctl.rd_idx];
    assign o_count   = r_count;
endmodule

>>> sv/rolling_median_mad_hampel_top.sv
// Top level: rolling median / MAD / Hampel score over a streamed Q16.16 series.
//
// i_in carries one sample per beat (sample, sample_missing, series_end).
// o_out carries one result per series index, in index order (value, status,
// series_last). i_cfg writes register index/data; ready is always high.
// Results trail the input by the alignment delay: w-1 (left), w-1-w/2
// (center), 0 (right). The beat with series_end flushes every pending index.
// The median and MAD take two serial passes over the window ring RAM, one
// read a cycle, each feeding the insertion sorter; a Hampel score adds a
// multiply and a 31-step restoring divide. Median-only results skip the
// second pass.
// A beat is taken only while no result is being computed; a finished result
// sits in the output register, so a stalled receiver holds the block only
// when the next result is ready to load.
// Reset clears pointers, counters, the stride phase and the output register
// and loads the register defaults (5, 1, 1, 0, 2). The window RAM needs no
// clearing.
module rolling_median_mad_hampel_top import hmp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hmp_in_if.sink    i_in,
    hmp_out_if.source o_out,
    hmp_cfg_if.sink   i_cfg
);
    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_COL, S_MA, S_MB, S_MC, S_XRD, S_XWAIT,
        S_MUL, S_HAMP, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic [5:0]  r_cfg_width;
    logic [15:0] r_cfg_step;
    logic [1:0]  r_cfg_align;
    logic        r_cfg_drop;
    logic [1:0]  r_cfg_stat;

    logic [IDX_W-1:0] r_wp;
    logic [31:0]      r_seen;
    logic [15:0]      r_phase;

    logic [31:0]      r_c;
    logic [31:0]      r_i;
    logic [IDX_W-1:0] r_base;
    logic             r_end;

    logic [CNT_W-1:0] r_k;
    logic [IDX_W-1:0] r_s;
    logic             r_pend;
    logic             r_poison;
    logic             r_pass;
    t_sval            r_ma;
    logic signed [SVAL_W:0] r_sum;
    t_sval            r_med;
    t_sval            r_mad;
    logic [31:0]      r_dev;
    logic [48:0]      r_den;
    logic [63:0]      r_rem;
    logic [78:0]      r_dsh;
    logic [30:0]      r_q;
    logic [4:0]       r_dcnt;
    logic [31:0]      r_res_val;
    t_status          r_res_st;

    logic        r_ov;
    logic [31:0] r_oval;
    t_status     r_ost;
    logic        r_olast;

    logic [CNT_W-1:0] w_w, w_lo, w_hi, w_d;
    logic [1:0]       w_a;
    logic [15:0]      w_st;
    logic             w_in_acc;
    logic             w_out_free;
    logic             w_sel_hampel;

    logic             w_ram_we;
    logic [IDX_W-1:0] w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_sort_ctl        w_sctl;
    t_sval            w_srd;
    logic [CNT_W-1:0] w_scnt;
    logic [CNT_W-1:0] w_cnt_m1;

    t_sval            w_sx;
    t_sval            w_diff;
    t_sval            w_abs;
    logic [32:0]      w_ihi;
    logic [32:0]      w_lim;
    logic [16:0]      w_phase_inc;
    logic             w_div_ge;
    logic [30:0]      w_q_next;
    logic signed [SVAL_W:0] w_half;

    assign w_w  = f_eff_width(r_cfg_width);
    assign w_a  = f_eff_align(r_cfg_align);
    assign w_lo = f_lo(w_w, w_a);
    assign w_hi = f_hi(w_w, w_a);
    assign w_d  = f_delay(w_w, w_a);
    assign w_st = (r_cfg_step == 16'd0) ? 16'd1 : r_cfg_step;
    assign w_sel_hampel = (r_cfg_stat != SEL_MEDIAN) && (r_cfg_stat != SEL_MAD);

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign w_out_free  = !r_ov || o_out.ready;

    assign w_sx   = {{(SVAL_W-SAMPLE_BITS){w_rdata[SAMPLE_BITS-1]}}, w_rdata[SAMPLE_BITS-1:0]};
    assign w_diff = w_sx - r_med;
    assign w_abs  = (w_diff < 0) ? -w_diff : w_diff;
    assign w_ihi  = {1'b0, r_i} + 33'(w_hi);
    assign w_lim  = r_end ? {1'b0, r_c} : ({1'b0, r_c} + 33'd1);
    assign w_phase_inc = {1'b0, r_phase} + 17'd1;
    assign w_div_ge = {15'd0, r_rem} >= r_dsh;
    assign w_q_next = {r_q[29:0], w_div_ge};
    assign w_half = (r_sum + ((r_sum < 0) ? (SVAL_W+1)'(1) : (SVAL_W+1)'(0))) >>> 1;
    assign w_cnt_m1 = w_scnt - CNT_W'(1);

    assign w_ram_we = w_in_acc;

    always_comb begin
        w_raddr = r_base + r_s;
        if (r_state == S_XRD) begin
            w_raddr = r_base + r_i[IDX_W-1:0];
        end
    end

    always_comb begin
        w_sctl.clear  = (r_state == S_EMIT) || (r_state == S_MC);
        w_sctl.ins    = (r_state == S_COL) && r_pend && !w_rdata[SAMPLE_BITS];
        w_sctl.val    = r_pass ? w_abs : w_sx;
        w_sctl.rd_idx = w_cnt_m1[CNT_W-1:1];
        if (r_state == S_MB) begin
            w_sctl.rd_idx = w_scnt[CNT_W-1:1];
        end
    end

    hmp_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WIDTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wp),
        .i_wdata ({i_in.sample_missing, i_in.sample}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hmp_sorter u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_sctl),
        .o_rd_data (w_srd),
        .o_count   (w_scnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= 6'd5;
            r_cfg_step  <= 16'd1;
            r_cfg_align <= AL_CENTER;
            r_cfg_drop  <= 1'b0;
            r_cfg_stat  <= 2'd2;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WIDTH: r_cfg_width <= i_cfg.data[5:0];
                REG_STEP:  r_cfg_step  <= i_cfg.data;
                REG_ALIGN: r_cfg_align <= i_cfg.data[1:0];
                REG_DROP:  r_cfg_drop  <= i_cfg.data[0];
                REG_STAT:  r_cfg_stat  <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_seen  <= '0;
            r_phase <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_c    <= r_seen;
                        r_base <= r_wp - r_seen[IDX_W-1:0];
                        r_end  <= i_in.series_end;
                        if (i_in.series_end) begin
                            r_wp    <= '0;
                            r_seen  <= '0;
                            r_i     <= (r_seen >= 32'(w_d)) ? r_seen - 32'(w_d) : 32'd0;
                            r_state <= S_EMIT;
                        end else begin
                            r_wp <= r_wp + IDX_W'(1);
                            if (r_seen != 32'hFFFF_FFFF) begin
                                r_seen <= r_seen + 32'd1;
                            end
                            r_i <= r_seen - 32'(w_d);
                            if (r_seen >= 32'(w_d)) begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    r_res_val <= '0;
                    if (r_end && ({1'b0, r_c} + 33'd1 < 33'(w_w))) begin
                        r_res_st <= ST_SHORT;
                        r_state  <= S_OUT;
                    end else begin
                        r_res_st <= ST_MISSING;
                        if (r_i >= 32'(w_lo)) begin
                            r_phase <= (w_phase_inc >= {1'b0, w_st}) ? 16'd0
                                                                     : w_phase_inc[15:0];
                            if (r_phase == 16'd0 && w_ihi <= w_lim) begin
                                r_s      <= r_i[IDX_W-1:0] - w_lo[IDX_W-1:0];
                                r_k      <= '0;
                                r_pend   <= 1'b0;
                                r_poison <= 1'b0;
                                r_pass   <= 1'b0;
                                r_state  <= S_COL;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_COL: begin
                    if (r_k < w_w) begin
                        r_k <= r_k + CNT_W'(1);
                        r_s <= r_s + IDX_W'(1);
                    end
                    r_pend <= (r_k < w_w);
                    if (r_pend && w_rdata[SAMPLE_BITS] && !r_cfg_drop) begin
                        r_poison <= 1'b1;
                    end
                    if (r_k >= w_w && !r_pend) begin
                        if (r_poison || w_scnt == '0) begin
                            r_res_st <= ST_MISSING;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_MA;
                        end
                    end
                end
                S_MA: begin
                    r_ma    <= w_srd;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_sum   <= (SVAL_W+1)'(r_ma) + (SVAL_W+1)'(w_srd);
                    r_state <= S_MC;
                end
                S_MC: begin
                    if (!r_pass) begin
                        r_med <= w_half[SVAL_W-1:0];
                        if (r_cfg_stat == SEL_MEDIAN) begin
                            r_res_val <= w_half[31:0];
                            r_res_st  <= ST_VALID;
                            r_state   <= S_OUT;
                        end else begin
                            r_pass  <= 1'b1;
                            r_s     <= r_s - w_w[IDX_W-1:0];
                            r_k     <= '0;
                            r_state <= S_COL;
                        end
                    end else begin
                        r_mad <= w_half[SVAL_W-1:0];
                        if (!w_sel_hampel) begin
                            r_res_val <= (w_half > (SVAL_W+1)'(VALUE_MAX)) ? VALUE_MAX
                                                                          : w_half[31:0];
                            r_res_st  <= ST_VALID;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_XRD;
                        end
                    end
                end
                S_XRD: begin
                    r_state <= S_XWAIT;
                end
                S_XWAIT: begin
                    if (w_rdata[SAMPLE_BITS]) begin
                        r_res_st <= ST_MISSING;
                        r_state  <= S_OUT;
                    end else if (r_mad == '0) begin
                        r_state <= S_OUT;
                        if (w_abs == '0) begin
                            r_res_val <= '0;
                            r_res_st  <= ST_VALID;
                        end else begin
                            r_res_val <= VALUE_MAX;
                            r_res_st  <= ST_INF;
                        end
                    end else begin
                        r_dev   <= w_abs[31:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_den   <= 49'(KAPPA_Q16) * 49'(r_mad[31:0]);
                    r_state <= S_HAMP;
                end
                S_HAMP: begin
                    if (49'({r_dev, 1'b0}) >= r_den) begin
                        r_res_val <= VALUE_MAX;
                        r_res_st  <= ST_VALID;
                        r_state   <= S_OUT;
                    end else begin
                        r_rem   <= {r_dev, 32'd0};
                        r_dsh   <= {r_den, 30'd0};
                        r_q     <= '0;
                        r_dcnt  <= 5'd30;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_ge) begin
                        r_rem <= r_rem - r_dsh[63:0];
                    end
                    r_q    <= w_q_next;
                    r_dsh  <= r_dsh >> 1;
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd0) begin
                        r_res_val <= {1'b0, w_q_next};
                        r_res_st  <= ST_VALID;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_oval  <= (r_res_st == ST_VALID || r_res_st == ST_INF) ? r_res_val
                                                                               : 32'd0;
                        r_ost   <= r_res_st;
                        r_olast <= r_end && (r_i == r_c);
                        if (r_end && r_i != r_c) begin
                            r_i     <= r_i + 32'd1;
                            r_state <= S_EMIT;
                        end else begin
                            if (r_end) begin
                                r_phase <= '0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.value       = r_oval;
    assign o_out.status      = r_ost;
    assign o_out.series_last = r_olast;

    a_sort_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL) |-> (w_scnt <= w_w))
        else $error("sorter holds more entries than the window");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.series_end) |=> (r_seen == '0 && r_wp == '0))
        else $error("series end did not clear the ring pointers");

    a_inf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_INF) |-> (o_out.value == VALUE_MAX))
        else $error("infinite score without saturated value");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_in.ready)
        else $error("input taken while a score is in progress");
endmodule

>>> bench/tb_rolling_median_mad_hampel_top.sv
// Testbench: random and directed series through the rolling median/MAD/Hampel block, scoreboarded.
`timescale 1ns / 100ps

module tb_rolling_median_mad_hampel_top;
    import hmp_pkg::*;

    typedef struct {
        logic [31:0] sample;
        logic        missing;
        logic        last;
    } t_sample_beat;

    typedef struct {
        logic [31:0] value;
        t_status     status;
        logic        last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hmp_in_if  in_ch();
    hmp_out_if out_ch();
    hmp_cfg_if cfg_ch();

    rolling_median_mad_hampel_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_sample_beat sample_fifo[$];
    t_result      results_due[$];
    int           n_errors = 0;
    bit           quiet = 1'b0;

    // predictor state
    logic [32:0]     ring[MAX_WIDTH];
    int unsigned     ring_ptr;
    longint unsigned n_seen;
    int unsigned     stride_pos;
    logic [5:0]      r_width;
    logic [15:0]     r_step;
    logic [1:0]      r_align;
    logic            r_drop;
    logic [1:0]      r_stat;
    longint          scratch[MAX_WIDTH];

    function automatic longint mid_of(int n);
        longint v;
        int j;
        for (int i = 1; i < n; i++) begin
            v = scratch[i];
            for (j = i; j > 0 && scratch[j-1] > v; j--) scratch[j] = scratch[j-1];
            scratch[j] = v;
        end
        if (n % 2 == 1) return scratch[n/2];
        return (scratch[n/2-1] + scratch[n/2]) / 2;
    endfunction

    function automatic int unsigned ring_slot(longint unsigned s, longint unsigned c,
                                              int unsigned cur);
        return (cur + MAX_WIDTH - int'((c - s) % MAX_WIDTH)) % MAX_WIDTH;
    endfunction

    function automatic longint unsigned width_now();
        if (r_width == 0) return 1;
        if (r_width > MAX_WIDTH) return MAX_WIDTH;
        return r_width;
    endfunction

    function automatic t_result score_index(longint unsigned i, longint unsigned c,
                                            int unsigned cur, bit fin, bit last);
        t_result r;
        longint unsigned w, st, lo, hi, lim, first;
        logic [1:0] a;
        longint med, mad, d;
        logic [63:0] dev, q;
        logic [32:0] e;
        int n;
        bit picked, gone;
        w = width_now();
        st = (r_step == 0) ? 1 : r_step;
        a = (r_align > AL_RIGHT) ? AL_RIGHT : r_align;
        lo = (a == AL_LEFT) ? 0 : ((a == AL_CENTER) ? w / 2 : w - 1);
        hi = (a == AL_LEFT) ? w - 1 : ((a == AL_CENTER) ? w / 2 : 0);
        lim = fin ? c : c + 1;
        r.value = '0;
        r.status = ST_MISSING;
        r.last = last;
        picked = 1'b0;
        if (fin && c + 1 < w) begin
            r.status = ST_SHORT;
        end else begin
            if (i >= lo) begin
                picked = (stride_pos == 0);
                stride_pos++;
                if (stride_pos >= st) stride_pos = 0;
            end
            if (picked && i + hi <= lim) begin
                first = i - lo;
                n = 0;
                gone = 1'b0;
                for (longint unsigned k = 0; k < w; k++) begin
                    e = ring[ring_slot(first + k, c, cur)];
                    if (e[32]) begin
                        if (!r_drop) gone = 1'b1;
                    end else begin
                        scratch[n] = longint'($signed(e[31:0]));
                        n++;
                    end
                end
                if (!gone && n > 0) begin
                    med = mid_of(n);
                    for (int k = 0; k < n; k++) begin
                        d = scratch[k] - med;
                        scratch[k] = d < 0 ? -d : d;
                    end
                    mad = mid_of(n);
                    if (r_stat == SEL_MEDIAN) begin
                        r.value = med[31:0];
                        r.status = ST_VALID;
                    end else if (r_stat == SEL_MAD) begin
                        r.value = (mad > longint'(VALUE_MAX)) ? VALUE_MAX : mad[31:0];
                        r.status = ST_VALID;
                    end else begin
                        e = ring[ring_slot(i, c, cur)];
                        if (!e[32]) begin
                            d = longint'($signed(e[31:0])) - med;
                            dev = d < 0 ? -d : d;
                            if (mad == 0) begin
                                if (dev == 0) begin
                                    r.status = ST_VALID;
                                end else begin
                                    r.value = VALUE_MAX;
                                    r.status = ST_INF;
                                end
                            end else begin
                                q = (dev << 32) / (64'd97164 * 64'(mad));
                                r.value = (q > 64'(VALUE_MAX)) ? VALUE_MAX : q[31:0];
                                r.status = ST_VALID;
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic predict_beat(t_sample_beat b);
        longint unsigned c, d, w, i;
        int unsigned cur;
        logic [1:0] a;
        int cnt;
        c = n_seen;
        cur = ring_ptr % MAX_WIDTH;
        w = width_now();
        a = (r_align > AL_RIGHT) ? AL_RIGHT : r_align;
        d = (a == AL_LEFT) ? w - 1 : ((a == AL_CENTER) ? w - 1 - w / 2 : 0);
        ring[cur] = {b.missing, b.sample};
        ring_ptr = (cur + 1) % MAX_WIDTH;
        if (n_seen != 64'hFFFF_FFFF) n_seen++;
        if (!b.last) begin
            if (c >= d) results_due.push_back(score_index(c - d, c, cur, 1'b0, 1'b0));
        end else begin
            cnt = 0;
            for (i = (c >= d) ? c - d : 0; i <= c && cnt < MAX_WIDTH; i++, cnt++)
                results_due.push_back(score_index(i, c, cur, 1'b1, i == c));
            n_seen = 0;
            stride_pos = 0;
            ring_ptr = 0;
        end
    endtask

    // sample driver
    int gap_in = 0;
    always @(posedge i_clk) begin
        t_sample_beat b;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                b.sample = in_ch.sample;
                b.missing = in_ch.sample_missing;
                b.last = in_ch.series_end;
                predict_beat(b);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_in > 0) begin
                    gap_in--;
                    in_ch.valid <= 1'b0;
                end else if (sample_fifo.size() > 0) begin
                    b = sample_fifo.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.sample <= b.sample;
                    in_ch.sample_missing <= b.missing;
                    in_ch.series_end <= b.last;
                    if (!quiet && $urandom_range(0, 3) == 0) gap_in = $urandom_range(1, 14);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    int  stall_out = 0;
    bit  held_once = 1'b0;
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (results_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result beat value=%h status=%0d",
                                                 out_ch.value, out_ch.status);
                end else begin
                    exp_r = results_due.pop_front();
                    if (out_ch.value !== exp_r.value || out_ch.status !== exp_r.status ||
                        out_ch.series_last !== exp_r.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                     exp_r.value, exp_r.status, exp_r.last,
                                     out_ch.value, out_ch.status, out_ch.series_last);
                    end
                end
            end
            if (!held_once && out_ch.valid) begin
                held_once = 1'b1;
                stall_out = 400;
            end
            if (stall_out > 0) begin
                stall_out--;
                out_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_out = $urandom_range(0, 13);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_WIDTH: r_width = data[5:0];
            REG_STEP:  r_step = data;
            REG_ALIGN: r_align = data[1:0];
            REG_DROP:  r_drop = data[0];
            REG_STAT:  r_stat = data[1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regs(int w, int st, int al, int dr, int sel);
        reg_write(REG_WIDTH, 16'(w));
        reg_write(REG_STEP, 16'(st));
        reg_write(REG_ALIGN, 16'(al));
        reg_write(REG_DROP, 16'(dr));
        reg_write(REG_STAT, 16'(sel));
    endtask

    task automatic push_beat(logic [31:0] s, logic m, logic e);
        t_sample_beat b;
        b.sample = s;
        b.missing = m;
        b.last = e;
        sample_fifo.push_back(b);
    endtask

    task automatic random_series(int len);
        logic [31:0] base, s;
        int kind;
        base = $urandom;
        for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) s = (32'($urandom_range(0, 15)) << 16) - 32'h0008_0000;
            else if (kind < 7) s = $urandom;
            else s = base;
            push_beat(s, $urandom_range(0, 11) == 0, k == len - 1);
        end
    endtask

    task automatic drain();
        wait (sample_fifo.size() == 0 && !in_ch.valid && results_due.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    int cfgs[7][5] = '{'{1, 1, 0, 0, 0}, '{32, 1, 2, 1, 1}, '{0, 0, 3, 1, 3},
                       '{40, 3, 1, 0, 2}, '{8, 65535, 0, 1, 2}, '{6, 2, 1, 1, 0},
                       '{5, 1, 1, 0, 2}};

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.sample_missing = 1'b0;
        in_ch.series_end = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_WIDTH;
        cfg_ch.data = '0;
        r_width = 6'd5;
        r_step = 16'd1;
        r_align = AL_CENTER;
        r_drop = 1'b0;
        r_stat = 2'd2;
        ring_ptr = 0;
        n_seen = 0;
        stride_pos = 0;
        foreach (ring[k]) ring[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero MAD, infinite score, missing, short series
        push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        push_beat(32'h0000_0000, 1'b0, 1'b0);
        push_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        push_beat(32'h8000_0000, 1'b0, 1'b0);
        push_beat(32'h0001_0000, 1'b1, 1'b0);
        for (int k = 0; k < 5; k++) push_beat(32'h0002_0000, 1'b0, 1'b0);
        push_beat(32'h0009_0000, 1'b0, 1'b0);
        for (int k = 0; k < 4; k++) push_beat(32'h0002_0000, 1'b0, k == 3);
        push_beat(32'h1234_5678, 1'b0, 1'b0);
        push_beat(32'hEDCB_A987, 1'b0, 1'b0);
        push_beat(32'h0000_0001, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 7; p++) begin
            set_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
            if (p == 6) quiet = 1'b1;
            if (p == 1) begin
                random_series(36);
            end else begin
                random_series($urandom_range(1, 4));
                random_series($urandom_range(6, 14));
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
sv/hmp_pkg.sv
sv/hmp_if.sv
sv/hmp_ram.sv
sv/hmp_sorter.sv
sv/rolling_median_mad_hampel_top.sv
bench/tb_rolling_median_mad_hampel_top.sv
